/* rtl/core/vne_pkg.sv */
// shared types, constants and the reciprocal square root table of the normal estimator
package vne_pkg;

  localparam int VNE_MAX_X = 32;
  localparam int VNE_MAX_Y = 32;
  localparam int VNE_MAX_Z = 32;

  localparam int VNE_SIZE_W = 6;
  localparam logic [VNE_SIZE_W-1:0] VNE_SIZE_RST = 6'd32;

  localparam int VNE_COORD_W = 5;
  localparam int VNE_LEN2_W = 7;
  localparam int VNE_RSQ_W = 17;
  localparam int VNE_RSQ_DEPTH = 76;

  // register indexes on the configuration port
  localparam logic [1:0] VNE_REG_SIZE_X = 2'd0;
  localparam logic [1:0] VNE_REG_SIZE_Y = 2'd1;
  localparam logic [1:0] VNE_REG_SIZE_Z = 2'd2;

  // input kind carried on tuser
  localparam logic VNE_ACT_WRITE = 1'b0;
  localparam logic VNE_ACT_COMPUTE = 1'b1;

  typedef struct packed {
    logic [VNE_SIZE_W-1:0] sx;
    logic [VNE_SIZE_W-1:0] sy;
    logic [VNE_SIZE_W-1:0] sz;
  } vne_size_t;

  // gathered neighbourhood of one compute request
  typedef struct packed {
    logic              occ;
    logic signed [3:0] sx;
    logic signed [3:0] sy;
    logic signed [3:0] sz;
  } vne_sum_t;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_WRD    = 6'b000100,
    S_WWR    = 6'b001000,
    S_GATHER = 6'b010000,
    S_HAND   = 6'b100000
  } vne_state_t;

  typedef logic [VNE_RSQ_W-1:0] vne_rsq_rom_t [0:VNE_RSQ_DEPTH-1];

  // round(65536/sqrt(l)), half up, by bisection at elaboration
  function automatic vne_rsq_rom_t vne_build_rsq();
    vne_rsq_rom_t rom;
    longint lo;
    longint hi;
    longint mid;
    longint d;
    for (int l = 0; l < VNE_RSQ_DEPTH; l++) begin
      if (l == 0) begin
        rom[l] = '0;
      end else begin
        lo = 1;
        hi = 65536;
        while (lo < hi) begin
          mid = (lo + hi + 1) / 2;
          d = 2 * mid - 1;
          if (d * d * longint'(l) <= (longint'(1) << 34)) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
        rom[l] = VNE_RSQ_W'(lo);
      end
    end
    return rom;
  endfunction

  localparam vne_rsq_rom_t VNE_RSQ_ROM = vne_build_rsq();

endpackage

/* rtl/core/vne_occ_ram.sv */
// single-port occupancy memory, one row of z bits per (x, y) column
module vne_occ_ram #(
  parameter int ROWS = 1024,
  parameter int WIDTH = 32,
  parameter int AW = 10
) (
  input  logic             clk,
  input  logic [AW-1:0]    addr,
  input  logic             rd_en,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [0:ROWS-1];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/vne_seq.sv */
// request sequencer: memory clear, bit writes and neighbourhood gathering
module vne_seq
  import vne_pkg::*;
#(
  parameter int MAX_X = VNE_MAX_X,
  parameter int MAX_Y = VNE_MAX_Y,
  parameter int MAX_Z = VNE_MAX_Z,
  parameter int ROWS = MAX_X * MAX_Y,
  parameter int AW = (ROWS > 1) ? $clog2(ROWS) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vne_size_t              sizes,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_action,
  input  logic [VNE_COORD_W-1:0] in_x,
  input  logic [VNE_COORD_W-1:0] in_y,
  input  logic [VNE_COORD_W-1:0] in_z,
  input  logic                   in_occ,
  output logic [AW-1:0]          mem_addr,
  output logic                   mem_rd,
  output logic                   mem_wr,
  output logic [MAX_Z-1:0]       mem_wdata,
  input  logic [MAX_Z-1:0]       mem_rdata,
  output logic                   res_valid,
  input  logic                   res_ready,
  output vne_sum_t               res
);

  localparam int ZAW = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;

  vne_state_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [VNE_COORD_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt;
  logic occ_r, occ_nxt;
  logic [1:0] ix_r, iy_r, ix_nxt, iy_nxt;
  logic iss_r, iss_nxt;
  logic pv_r, pv_nxt;
  logic prow_r, prow_nxt;
  logic [1:0] pix_r, piy_r, pix_nxt, piy_nxt;
  vne_sum_t acc_r, acc_nxt;

  function automatic logic signed [6:0] offs(input logic [1:0] i);
    return $signed({5'b0, i}) - 7'sd1;
  endfunction

  function automatic logic in_vol(input logic signed [6:0] n, input logic [5:0] size,
                                  input int cap);
    return !n[6] && (n[5:0] < size) && (int'(n[5:0]) < cap);
  endfunction

  logic signed [6:0] nx, ny, nzm, nz0, nzp;
  logic row_ok, zm_ok, z0_ok, zp_ok;
  logic em, e0, ep, am, a0, ap, corner, center;
  logic [1:0] cnt;
  logic [AW-1:0] gath_addr, wr_addr;
  logic wr_in_range;

  always_comb begin
    nx = $signed({2'b00, x_r}) + offs(ix_r);
    ny = $signed({2'b00, y_r}) + offs(iy_r);
    row_ok = in_vol(nx, sizes.sx, MAX_X) && in_vol(ny, sizes.sy, MAX_Y);
    gath_addr = AW'(int'(nx[5:0]) * MAX_Y + int'(ny[5:0]));
    wr_addr = AW'(int'(x_r) * MAX_Y + int'(y_r));
    wr_in_range = (int'(in_x) < MAX_X) && (int'(in_y) < MAX_Y) && (int'(in_z) < MAX_Z);

    nzm = $signed({2'b00, z_r}) - 7'sd1;
    nz0 = $signed({2'b00, z_r});
    nzp = $signed({2'b00, z_r}) + 7'sd1;
    zm_ok = in_vol(nzm, sizes.sz, MAX_Z);
    z0_ok = in_vol(nz0, sizes.sz, MAX_Z);
    zp_ok = in_vol(nzp, sizes.sz, MAX_Z);
    // empty means outside the volume or a clear bit
    em = !(prow_r && zm_ok && mem_rdata[ZAW'(nzm[5:0])]);
    e0 = !(prow_r && z0_ok && mem_rdata[ZAW'(nz0[5:0])]);
    ep = !(prow_r && zp_ok && mem_rdata[ZAW'(nzp[5:0])]);
    corner = (pix_r != 2'd1) && (piy_r != 2'd1);
    center = (pix_r == 2'd1) && (piy_r == 2'd1);
    am = !corner;
    ap = !corner;
    a0 = !center;
    cnt = 2'(am & em) + 2'(a0 & e0) + 2'(ap & ep);
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    x_nxt = x_r;
    y_nxt = y_r;
    z_nxt = z_r;
    occ_nxt = occ_r;
    ix_nxt = ix_r;
    iy_nxt = iy_r;
    iss_nxt = iss_r;
    pv_nxt = 1'b0;
    prow_nxt = prow_r;
    pix_nxt = pix_r;
    piy_nxt = piy_r;
    acc_nxt = acc_r;
    mem_addr = gath_addr;
    mem_rd = 1'b0;
    mem_wr = 1'b0;
    mem_wdata = '0;
    in_ready = 1'b0;
    res_valid = 1'b0;

    unique case (state_r)
      S_CLEAR: begin
        mem_addr = clr_r;
        mem_wr = 1'b1;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(ROWS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          x_nxt = in_x;
          y_nxt = in_y;
          z_nxt = in_z;
          occ_nxt = in_occ;
          if (in_action == VNE_ACT_COMPUTE) begin
            state_nxt = S_GATHER;
            ix_nxt = 2'd0;
            iy_nxt = 2'd0;
            iss_nxt = 1'b1;
            acc_nxt = '0;
          end else if (wr_in_range) begin
            state_nxt = S_WRD;
          end
        end
      end
      S_WRD: begin
        mem_addr = wr_addr;
        mem_rd = 1'b1;
        state_nxt = S_WWR;
      end
      S_WWR: begin
        mem_addr = wr_addr;
        mem_wr = 1'b1;
        mem_wdata = mem_rdata;
        mem_wdata[ZAW'(z_r)] = occ_r;
        state_nxt = S_IDLE;
      end
      S_GATHER: begin
        // issue one row read per cycle, fold in the row read the cycle before
        if (iss_r) begin
          mem_rd = row_ok;
          pv_nxt = 1'b1;
          prow_nxt = row_ok;
          pix_nxt = ix_r;
          piy_nxt = iy_r;
          if (iy_r == 2'd2) begin
            iy_nxt = 2'd0;
            ix_nxt = ix_r + 2'd1;
            if (ix_r == 2'd2) begin
              iss_nxt = 1'b0;
            end
          end else begin
            iy_nxt = iy_r + 2'd1;
          end
        end
        if (pv_r) begin
          if (pix_r == 2'd0) acc_nxt.sx = acc_r.sx - $signed({2'b00, cnt});
          if (pix_r == 2'd2) acc_nxt.sx = acc_r.sx + $signed({2'b00, cnt});
          if (piy_r == 2'd0) acc_nxt.sy = acc_r.sy - $signed({2'b00, cnt});
          if (piy_r == 2'd2) acc_nxt.sy = acc_r.sy + $signed({2'b00, cnt});
          acc_nxt.sz = acc_r.sz + $signed({3'b000, ap & ep}) - $signed({3'b000, am & em});
          if (center) begin
            acc_nxt.occ = !e0;
          end
          if (!iss_r) begin
            state_nxt = S_HAND;
          end
        end
      end
      S_HAND: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  assign res = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      iss_r <= 1'b0;
      pv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      iss_r <= iss_nxt;
      pv_r <= pv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
    occ_r <= occ_nxt;
    ix_r <= ix_nxt;
    iy_r <= iy_nxt;
    prow_r <= prow_nxt;
    pix_r <= pix_nxt;
    piy_r <= piy_nxt;
    acc_r <= acc_nxt;
  end

endmodule

/* rtl/core/vne_norm.sv */
// normalization pipeline and result register
module vne_norm
  import vne_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     req_valid,
  output logic     req_ready,
  input  vne_sum_t req,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_occ,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  vne_sum_t s1_r, s2_r;
  logic [VNE_LEN2_W-1:0] len2_r;
  logic [VNE_RSQ_W-1:0] rsq_r;
  logic s2_zero_r, s3_zero_r, s3_occ_r;
  logic [7:0] red_r, green_r, blue_r;
  logic occ_out_r;

  logic signed [7:0] ex, ey, ez;
  logic signed [7:0] len2_w;
  logic out_load;

  function automatic logic [17:0] clamp_t(input logic signed [3:0] s,
                                          input logic [VNE_RSQ_W-1:0] r);
    logic signed [21:0] p;
    p = $signed({5'b0, r}) * 22'(s) + 22'sd65536;
    if (p < 22'sd0) return 18'd0;
    if (p > 22'sd131072) return 18'd131072;
    return 18'(p);
  endfunction

  function automatic logic [7:0] to_byte(input logic [17:0] t);
    logic [25:0] w;
    w = 26'(t) * 26'd255;
    return w[24:17];
  endfunction

  function automatic logic signed [7:0] req_sx_ext(input logic signed [3:0] s);
    return 8'(s);
  endfunction

  always_comb begin
    ex = 8'(req_sx_ext(s1_r.sx));
    ey = 8'(req_sx_ext(s1_r.sy));
    ez = 8'(req_sx_ext(s1_r.sz));
    len2_w = ex * ex + ey * ey + ez * ez;
  end

  assign req_ready = !s1_v_r && !s2_v_r && !s3_v_r;
  assign out_load = s3_v_r && (!out_v_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r <= req_valid && req_ready;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r || (s3_v_r && !out_load);
      if (out_load) begin
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      s1_r <= req;
    end
    if (s1_v_r) begin
      s2_r <= s1_r;
      len2_r <= VNE_LEN2_W'(len2_w);
      s2_zero_r <= (len2_w == 8'sd0);
    end
    if (s2_v_r) begin
      rsq_r <= VNE_RSQ_ROM[len2_r];
    end
    if (s2_v_r) begin
      s3_occ_r <= s2_r.occ;
      s3_zero_r <= s2_zero_r;
    end
    if (out_load) begin
      occ_out_r <= s3_occ_r;
      if (!s3_occ_r) begin
        red_r <= 8'd0;
        green_r <= 8'd0;
        blue_r <= 8'd0;
      end else if (s3_zero_r) begin
        red_r <= 8'd127;
        green_r <= 8'd127;
        blue_r <= 8'd127;
      end else begin
        red_r <= to_byte(clamp_t(s2_r.sx, rsq_r));
        green_r <= to_byte(clamp_t(s2_r.sy, rsq_r));
        blue_r <= to_byte(clamp_t(s2_r.sz, rsq_r));
      end
    end
  end

  assign out_valid = out_v_r;
  assign out_occ = occ_out_r;
  assign out_red = red_r;
  assign out_green = green_r;
  assign out_blue = blue_r;

endmodule

/* rtl/core/voxel_normal_estimator.sv */
// voxel surface normal estimator top level: config registers, sequencer, memory, normalizer
//
// usage
// - in_*: one request per handshake; in_tuser is the kind (0 write bit, 1 compute normal),
//   in_tdata carries the voxel coordinate and, for writes, the bit to store
// - out_*: one result per compute request, none per write; out_tuser is 1 when the
//   queried voxel is occupied, out_tdata holds the normal as three bytes
// - apb port: size_x, size_y, size_z at byte addresses 0, 4, 8; change them only while idle
// - occupancy is one memory row of MAX_Z bits per (x, y) column, single port,
//   one access per cycle, read data registered and valid in the next cycle
// - a compute request goes through accept, nine row reads (each row gives the three
//   z neighbours at once), the last fold and the hand-off; the normalizer registers
//   it in s1, s2, s3 and the output register and overlaps the next request
// - a write request goes through accept, row read and row write back
// - reset: registers go to 32 and a clearing pass writes every row to zero, all
//   MAX_X*MAX_Y rows (1024 by default); in_tready stays low until it is done
// - when the receiver stalls, the result waits in the output register; the block
//   still takes writes and gathers the next compute request, then waits at hand-off
module voxel_normal_estimator
  import vne_pkg::*;
#(
  parameter int MAX_X = VNE_MAX_X,
  parameter int MAX_Y = VNE_MAX_Y,
  parameter int MAX_Z = VNE_MAX_Z
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,  // coord_x[4:0], coord_y[9:5], coord_z[14:10], occupied_in[15]
  input  logic        in_tuser,  // action[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata, // normal_red[7:0], normal_green[15:8], normal_blue[23:16]
  output logic        out_tuser, // occupied_out[0]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int ROWS = MAX_X * MAX_Y;
  localparam int AW = (ROWS > 1) ? $clog2(ROWS) : 1;

  // configuration registers
  vne_size_t sizes_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sizes_r.sx <= VNE_SIZE_RST;
      sizes_r.sy <= VNE_SIZE_RST;
      sizes_r.sz <= VNE_SIZE_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        VNE_REG_SIZE_X: sizes_r.sx <= pwdata[VNE_SIZE_W-1:0];
        VNE_REG_SIZE_Y: sizes_r.sy <= pwdata[VNE_SIZE_W-1:0];
        VNE_REG_SIZE_Z: sizes_r.sz <= pwdata[VNE_SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      VNE_REG_SIZE_X: prdata = 32'(sizes_r.sx);
      VNE_REG_SIZE_Y: prdata = 32'(sizes_r.sy);
      VNE_REG_SIZE_Z: prdata = 32'(sizes_r.sz);
      default:        prdata = 32'd0;
    endcase
  end

  // occupancy memory
  logic [AW-1:0] mem_addr;
  logic mem_rd, mem_wr;
  logic [MAX_Z-1:0] mem_wdata, mem_rdata;

  vne_occ_ram #(
    .ROWS (ROWS),
    .WIDTH(MAX_Z),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .addr (mem_addr),
    .rd_en(mem_rd),
    .wr_en(mem_wr),
    .wdata(mem_wdata),
    .rdata(mem_rdata)
  );

  // sequencer
  logic res_valid, res_ready;
  vne_sum_t res;

  vne_seq #(
    .MAX_X(MAX_X),
    .MAX_Y(MAX_Y),
    .MAX_Z(MAX_Z),
    .ROWS (ROWS),
    .AW   (AW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .sizes    (sizes_r),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_action(in_tuser),
    .in_x     (in_tdata[4:0]),
    .in_y     (in_tdata[9:5]),
    .in_z     (in_tdata[14:10]),
    .in_occ   (in_tdata[15]),
    .mem_addr (mem_addr),
    .mem_rd   (mem_rd),
    .mem_wr   (mem_wr),
    .mem_wdata(mem_wdata),
    .mem_rdata(mem_rdata),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // normalization and output register
  vne_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .req_valid(res_valid),
    .req_ready(res_ready),
    .req      (res),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_occ  (out_tuser),
    .out_red  (out_tdata[7:0]),
    .out_green(out_tdata[15:8]),
    .out_blue (out_tdata[23:16])
  );

endmodule

/* rtl/core/vne_checker.sv */
// port-level checks of the normal estimator and their binding
module vne_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        pready
);

  // the clearing pass keeps the input closed right after reset
  a_closed_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> !in_tready)
    else $error("input open right after reset");

  a_no_result_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> !out_tvalid)
    else $error("result shown right after reset");

  // an empty voxel gives black
  a_empty_black: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 24'd0)
    else $error("empty voxel with nonzero colour");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind voxel_normal_estimator vne_checker u_vne_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .pready    (pready)
);
